// ===== hdl/mbd_pkg.sv =====
// Shared constants and types of the mipmap box downsampler.
`timescale 1ns / 1ps
package mbd_pkg;

    localparam int DEF_MAX_DIM  = 4096;
    localparam int DEF_CHANNELS = 4;
    localparam int NUM_LANES    = 4;
    localparam int CHAN_W       = 8;
    localparam int SUM_W        = 10;
    localparam int CFG_W        = 13;
    localparam int LEVEL_W      = 4;
    localparam int COORD_W      = 11;
    localparam int IDX_W        = 1;

    localparam logic [IDX_W-1:0] REG_BASE_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_BASE_HEIGHT = 1'b1;

    typedef logic [NUM_LANES-1:0][CHAN_W-1:0] pixel_t;

    typedef struct packed {
        logic accept;
        logic rd;
        logic adv;
        logic stop;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic lvl_zero;
        logic done;
        logic last_lvl;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/mbd_if.sv =====
// Stream and configuration interfaces of the mipmap box downsampler.
`timescale 1ns / 1ps
interface mbd_pix_if;
    logic                      valid;
    logic                      ready;
    logic [mbd_pkg::CHAN_W-1:0] red;
    logic [mbd_pkg::CHAN_W-1:0] green;
    logic [mbd_pkg::CHAN_W-1:0] blue;
    logic [mbd_pkg::CHAN_W-1:0] alpha;
    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface mbd_tex_if;
    logic                        valid;
    logic                        ready;
    logic [mbd_pkg::LEVEL_W-1:0] mip_level;
    logic [mbd_pkg::COORD_W-1:0] texel_x;
    logic [mbd_pkg::COORD_W-1:0] texel_y;
    logic [mbd_pkg::CHAN_W-1:0]  out_red;
    logic [mbd_pkg::CHAN_W-1:0]  out_green;
    logic [mbd_pkg::CHAN_W-1:0]  out_blue;
    logic [mbd_pkg::CHAN_W-1:0]  out_alpha;
    logic                        last_of_run;
    modport source (output valid, mip_level, texel_x, texel_y, out_red, out_green,
                    out_blue, out_alpha, last_of_run, input ready);
    modport sink (input valid, mip_level, texel_x, texel_y, out_red, out_green,
                  out_blue, out_alpha, last_of_run, output ready);
endinterface

interface mbd_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [mbd_pkg::IDX_W-1:0] index;
    logic [mbd_pkg::CFG_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/mbd_ctrl.sv =====
// Sequencing state machine of the mipmap box downsampler.
`timescale 1ns / 1ps
module mbd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  mbd_pkg::status_t sts,
    output mbd_pkg::cmd_t    cmd,
    output logic             in_ready
);
    import mbd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_CALC,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.accept = 1'b1;
                    if (!sts.lvl_zero)
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (sts.done)
                begin
                    if (!sts.pend_valid || sts.out_free)
                    begin
                        cmd.adv    = 1'b1;
                        state_next = sts.last_lvl ? ST_FLUSH : ST_RD;
                    end
                end
                else
                begin
                    cmd.stop   = 1'b1;
                    state_next = sts.pend_valid ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ===== hdl/mbd_datapath.sv =====
// Level counters, pair sum memory, averaging and result registers.
`timescale 1ns / 1ps
module mbd_datapath #(
    parameter int MAX_DIM  = mbd_pkg::DEF_MAX_DIM,
    parameter int CHANNELS = mbd_pkg::DEF_CHANNELS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mbd_pkg::cmd_t               cmd,
    output mbd_pkg::status_t            sts,
    input  mbd_pkg::pixel_t             in_px,
    input  logic                        cfg_we,
    input  logic [mbd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [mbd_pkg::CFG_W-1:0]   cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mbd_pkg::LEVEL_W-1:0] out_level,
    output logic [mbd_pkg::COORD_W-1:0] out_x,
    output logic [mbd_pkg::COORD_W-1:0] out_y,
    output mbd_pkg::pixel_t             out_px,
    output logic                        out_last
);
    import mbd_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int AW    = $clog2(MAX_DIM);
    localparam int NLEV  = $clog2(MAX_DIM);
    localparam int SW    = $clog2(NLEV + 1);
    localparam int LW    = (NLEV > 1) ? $clog2(NLEV) : 1;
    localparam int NSLOT = 1 << LW;
    localparam int MW    = CHANNELS * SUM_W;
    localparam int OFF_W = DIM_W + 1;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0)
        begin
            return DIM_W'(1);
        end
        else if (v32 > 32'(MAX_DIM))
        begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v32);
    endfunction

    function automatic logic [DIM_W-1:0] max1(input logic [DIM_W-1:0] d);
        return (d == '0) ? DIM_W'(1) : d;
    endfunction

    logic [DIM_W-1:0]  w_reg, h_reg;
    logic [AW-1:0]     lcol_reg [NSLOT];
    logic [AW-1:0]     lrow_reg [NSLOT];
    logic [CHANNELS*CHAN_W-1:0] hold_mem [NSLOT];
    logic [MW-1:0]     sum_mem [MAX_DIM];
    logic [MW-1:0]     rsum_reg;
    logic [LW-1:0]     s_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [AW-1:0]     col_reg, row_reg, idx_reg;
    pixel_t            px_reg;
    logic              pend_valid_reg;
    logic [LEVEL_W-1:0] pend_level_reg;
    logic [COORD_W-1:0] pend_x_reg, pend_y_reg;
    pixel_t            pend_px_reg;
    logic              out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    pixel_t            out_px_reg;
    logic              out_last_reg;

    logic [DIM_W-1:0]  m_dim;
    logic [SW-1:0]     levels;
    logic [DIM_W-1:0]  sw, sh, dw, dh;
    logic              sw2, sh2;
    logic [AW-1:0]     lcol_s, lrow_s;
    logic [AW-1:0]     ncol, nrow;
    logic [OFF_W:0]    idx_sum;
    logic [AW-1:0]     idx_rd;
    logic              in_range, pair_ready, done;
    logic [CHANNELS*CHAN_W-1:0] hold_s;
    logic [MW-1:0]     pair_bus;
    pixel_t            res_px;
    logic [1:0]        shift;
    logic              out_free;

    always_comb
    begin
        m_dim  = (w_reg > h_reg) ? w_reg : h_reg;
        levels = '0;
        for (int i = 1; i < DIM_W; i++)
        begin
            if (m_dim[i])
            begin
                levels = SW'(i);
            end
        end
    end

    assign sw  = max1(w_reg >> s_reg);
    assign sh  = max1(h_reg >> s_reg);
    assign dw  = max1(w_reg >> (32'(s_reg) + 32'd1));
    assign dh  = max1(h_reg >> (32'(s_reg) + 32'd1));
    assign sw2 = (sw != DIM_W'(1));
    assign sh2 = (sh != DIM_W'(1));

    assign lcol_s = lcol_reg[s_reg];
    assign lrow_s = lrow_reg[s_reg];

    always_comb
    begin
        ncol = lcol_s + AW'(1);
        nrow = lrow_s;
        if ((DIM_W'(lcol_s) + DIM_W'(1)) >= sw)
        begin
            ncol = '0;
            nrow = lrow_s + AW'(1);
            if ((DIM_W'(lrow_s) + DIM_W'(1)) >= sh)
            begin
                nrow = '0;
            end
        end
    end

    assign idx_sum = (OFF_W+1)'(off_reg) + (OFF_W+1)'(lcol_s >> 1);
    assign idx_rd  = (idx_sum >= (OFF_W+1)'(MAX_DIM)) ? AW'(MAX_DIM - 1) : AW'(idx_sum);

    assign in_range   = ((OFF_W)'(col_reg) < {1'b0, dw} << 1)
                        && ((OFF_W)'(row_reg) < {1'b0, dh} << 1);
    assign pair_ready = in_range && (!sw2 || col_reg[0]);
    assign done       = pair_ready && (!sh2 || row_reg[0]);
    assign shift      = {1'b0, sw2} + {1'b0, sh2};
    assign hold_s     = hold_mem[s_reg];

    for (genvar c = 0; c < NUM_LANES; c++)
    begin : g_lane
        if (c < CHANNELS)
        begin : g_on
            logic [SUM_W-1:0] pair, total;
            assign pair  = sw2 ? SUM_W'(hold_s[c*CHAN_W +: CHAN_W]) + SUM_W'(px_reg[c])
                               : SUM_W'(px_reg[c]);
            assign total = sh2 ? rsum_reg[c*SUM_W +: SUM_W] + pair : pair;
            assign pair_bus[c*SUM_W +: SUM_W] = pair;
            assign res_px[c] = CHAN_W'(total >> shift);
        end
        else
        begin : g_off
            assign res_px[c] = '0;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rsum_reg <= sum_mem[idx_rd];
        end
        if (cmd.stop && pair_ready && sh2 && !row_reg[0])
        begin
            sum_mem[idx_reg] <= pair_bus;
        end
        if (cmd.stop && in_range && sw2 && !col_reg[0])
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                hold_mem[s_reg][c*CHAN_W +: CHAN_W] <= px_reg[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg <= in_px;
        end
        else if (cmd.adv)
        begin
            px_reg <= res_px;
        end
        if (cmd.rd)
        begin
            col_reg <= lcol_s;
            row_reg <= lrow_s;
            idx_reg <= idx_rd;
        end
        if (cmd.adv)
        begin
            pend_level_reg <= LEVEL_W'(32'(s_reg) + 32'd1);
            pend_x_reg     <= COORD_W'(col_reg >> 1);
            pend_y_reg     <= COORD_W'(row_reg >> 1);
            pend_px_reg    <= res_px;
        end
        if (cmd.adv && pend_valid_reg)
        begin
            out_level_reg <= pend_level_reg;
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_px_reg    <= pend_px_reg;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.flush)
        begin
            out_level_reg <= pend_level_reg;
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_px_reg    <= pend_px_reg;
            out_last_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg          <= DIM_W'(1);
            h_reg          <= DIM_W'(1);
            s_reg          <= '0;
            off_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NSLOT; i++)
            begin
                lcol_reg[i] <= '0;
                lrow_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE_WIDTH:  w_reg <= clamp_dim(cfg_data);
                    REG_BASE_HEIGHT: h_reg <= clamp_dim(cfg_data);
                    default:         w_reg <= w_reg;
                endcase
                for (int i = 0; i < NSLOT; i++)
                begin
                    lcol_reg[i] <= '0;
                    lrow_reg[i] <= '0;
                end
            end
            else if (cmd.rd)
            begin
                lcol_reg[s_reg] <= ncol;
                lrow_reg[s_reg] <= nrow;
            end
            if (cmd.accept)
            begin
                s_reg          <= '0;
                off_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.adv)
            begin
                s_reg          <= s_reg + LW'(1);
                off_reg        <= off_reg + OFF_W'(dw);
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.adv && pend_valid_reg) || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.lvl_zero   = (levels == '0);
    assign sts.done       = done;
    assign sts.last_lvl   = ((SW+1)'(s_reg) + (SW+1)'(1)) == (SW+1)'(levels);
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_level = out_level_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_px    = out_px_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hdl/mipmap_box_downsampler.sv =====
// Top level of the streaming 2x2 box filter mip chain generator.
//
//   Channel | Role   | Payload
//   pix     | input  | red, green, blue, alpha of one base pixel
//   tex     | output | mip_level, texel_x, texel_y, out_* channels, last_of_run
//   cfg     | config | index (0 base_width, 1 base_height), data
//
// One pixel is accepted in the idle state and then, for every level it reaches,
// reads the pair sum memory through its registered port before averaging.
// A pixel that yields texels then passes a flush state to hand its last texel over.
// When the image has no levels at all, the pixel is taken without a cascade.
// Output stalls hold the cascade once a result waits behind a full output register.
// Reset clears the level counters; the pair sum memory needs no clearing.
`timescale 1ns / 1ps
module mipmap_box_downsampler #(
    parameter int MAX_DIM  = mbd_pkg::DEF_MAX_DIM,
    parameter int CHANNELS = mbd_pkg::DEF_CHANNELS
) (
    input logic  clk,
    input logic  rst_n,
    mbd_pix_if.sink   pix,
    mbd_tex_if.source tex,
    mbd_cfg_if.sink   cfg
);
    import mbd_pkg::*;

    cmd_t    cmd;
    status_t sts;
    pixel_t  in_px;
    pixel_t  out_px;
    logic    in_ready;

    assign in_px = {pix.alpha, pix.blue, pix.green, pix.red};
    assign pix.ready = in_ready;
    assign cfg.ready = 1'b1;

    mbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    mbd_datapath #(
        .MAX_DIM  (MAX_DIM),
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_px     (in_px),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_valid (tex.valid),
        .out_ready (tex.ready),
        .out_level (tex.mip_level),
        .out_x     (tex.texel_x),
        .out_y     (tex.texel_y),
        .out_px    (out_px),
        .out_last  (tex.last_of_run)
    );

    assign tex.out_red   = out_px[0];
    assign tex.out_green = out_px[1];
    assign tex.out_blue  = out_px[2];
    assign tex.out_alpha = out_px[3];

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready && !sts.lvl_zero) |=> !pix.ready)
        else $error("input still ready after a transfer that starts a cascade");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");

    a_pending_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.pend_valid |-> !pix.ready)
        else $error("input ready while a texel is still pending");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the mipmap box downsampler with a built-in mip chain predictor.
`timescale 1ns / 1ps
module tb_top;
    import mbd_pkg::*;

    localparam int MAXD = 4096;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [LEVEL_W-1:0] mip_level;
        logic [COORD_W-1:0] texel_x;
        logic [COORD_W-1:0] texel_y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        logic               last_of_run;
    } texel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mbd_pix_if pix();
    mbd_tex_if tex();
    mbd_cfg_if cfg();

    mipmap_box_downsampler i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .pix(pix.sink),
        .tex(tex.source),
        .cfg(cfg.sink)
    );

    always #6 clk = ~clk;

    pixel_t     pixel_queue[$];
    texel_t     texel_queue[$];
    int         errors = 0;
    int         idle_cycles = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_phase = 0;
    bit         stall_mode = 1'b0;

    int unsigned img_w = 1;
    int unsigned img_h = 1;
    int unsigned pair_sum_mem[MAXD][4];
    int unsigned hold_mem[16][4];
    int unsigned lvl_col[16];
    int unsigned lvl_row[16];

    function automatic void add_pixel(pixel_t p);
        pixel_queue.insert(pixel_queue.size(), p);
    endfunction

    function automatic int unsigned dim_at(int unsigned base, int unsigned k);
        int unsigned d;
        d = base >> k;
        return (d < 1) ? 1 : d;
    endfunction

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAXD)
            return MAXD;
        return v;
    endfunction

    task automatic set_dim(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        if (idx == REG_BASE_WIDTH)
            img_w = clamp_dim(v);
        else
            img_h = clamp_dim(v);
        for (int i = 0; i < 16; i++)
        begin
            lvl_col[i] = 0;
            lvl_row[i] = 0;
        end
    endtask

    task automatic predict_mips(pixel_t p);
        int unsigned px[4], pair[4], total[4];
        int unsigned m, levels, off, sw, sh, dw, dh, col, row, idx, sh_amt;
        int n;
        bit pair_ok, done;
        texel_t t;
        n = 0;
        off = 0;
        m = (img_w > img_h) ? img_w : img_h;
        levels = 0;
        while (m > 1)
        begin
            m >>= 1;
            levels++;
        end
        for (int c = 0; c < 4; c++)
            px[c] = p[c];
        for (int s = 0; s < levels; s++)
        begin
            sw = dim_at(img_w, s);
            sh = dim_at(img_h, s);
            dw = dim_at(img_w, s + 1);
            dh = dim_at(img_h, s + 1);
            col = lvl_col[s];
            row = lvl_row[s];
            pair_ok = 1'b0;
            done = 1'b0;
            if (col + 1 >= sw)
            begin
                lvl_col[s] = 0;
                lvl_row[s] = (row + 1 >= sh) ? 0 : row + 1;
            end
            else
                lvl_col[s] = col + 1;
            if (col < 2 * dw && row < 2 * dh)
            begin
                if (sw >= 2)
                begin
                    if (col[0] == 1'b0)
                        for (int c = 0; c < 4; c++)
                            hold_mem[s][c] = px[c];
                    else
                    begin
                        for (int c = 0; c < 4; c++)
                            pair[c] = hold_mem[s][c] + px[c];
                        pair_ok = 1'b1;
                    end
                end
                else
                begin
                    for (int c = 0; c < 4; c++)
                        pair[c] = px[c];
                    pair_ok = 1'b1;
                end
                if (pair_ok)
                begin
                    idx = off + (col >> 1);
                    if (idx >= MAXD)
                        idx = MAXD - 1;
                    if (sh >= 2)
                    begin
                        if (row[0] == 1'b0)
                            for (int c = 0; c < 4; c++)
                                pair_sum_mem[idx][c] = pair[c];
                        else
                        begin
                            for (int c = 0; c < 4; c++)
                                total[c] = pair_sum_mem[idx][c] + pair[c];
                            done = 1'b1;
                        end
                    end
                    else
                    begin
                        for (int c = 0; c < 4; c++)
                            total[c] = pair[c];
                        done = 1'b1;
                    end
                end
            end
            off += dw;
            if (!done)
                break;
            sh_amt = (sw >= 2 ? 1 : 0) + (sh >= 2 ? 1 : 0);
            for (int c = 0; c < 4; c++)
                px[c] = (total[c] >> sh_amt) & 8'hFF;
            t.mip_level = LEVEL_W'(s + 1);
            t.texel_x = COORD_W'(col >> 1);
            t.texel_y = COORD_W'(row >> 1);
            t.red = CHAN_W'(px[0]);
            t.green = CHAN_W'(px[1]);
            t.blue = CHAN_W'(px[2]);
            t.alpha = CHAN_W'(px[3]);
            t.last_of_run = 1'b0;
            texel_queue.insert(texel_queue.size(), t);
            n++;
        end
        if (n > 0)
            texel_queue[texel_queue.size() - 1].last_of_run = 1'b1;
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix.valid <= 1'b0;
            pix.red <= '0;
            pix.green <= '0;
            pix.blue <= '0;
            pix.alpha <= '0;
        end
        else
        begin
            if (pix.valid && pix.ready)
                predict_mips({pix.alpha, pix.blue, pix.green, pix.red});
            if (!pix.valid || pix.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    pix.valid <= 1'b0;
                end
                else if (pixel_queue.size() > 0)
                begin
                    pixel_t p;
                    p = pixel_queue.pop_front();
                    pix.valid <= 1'b1;
                    pix.red <= p[0];
                    pix.green <= p[1];
                    pix.blue <= p[2];
                    pix.alpha <= p[3];
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    pix.valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls on its own pattern, with calm stretches.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tex.ready <= 1'b0;
        else
        begin
            if (tex.valid && tex.ready)
            begin
                texel_t got, want;
                got = {tex.mip_level, tex.texel_x, tex.texel_y, tex.out_red, tex.out_green,
                       tex.out_blue, tex.out_alpha, tex.last_of_run};
                if (texel_queue.size() == 0)
                begin
                    $display("%0t: unexpected texel %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = texel_queue.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: texel mismatch expected %h actual %h", $time, want, got);
                        errors++;
                    end
                end
            end
            stall_phase++;
            if (stall_phase % 64 == 0)
                stall_mode = 1'($urandom_range(0, 1));
            tex.ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (tex.valid && tex.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        set_dim(idx, v);
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pixel_queue.size() > 0 || pix.valid || !pix.ready || texel_queue.size() > 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        for (int c = 0; c < 4; c++)
            p[c] = CHAN_W'($urandom_range(0, 255));
        return p;
    endfunction

    task automatic run_image(int unsigned w, int unsigned h, int unsigned npix);
        write_reg(REG_BASE_WIDTH, CFG_W'(w));
        write_reg(REG_BASE_HEIGHT, CFG_W'(h));
        for (int i = 0; i < npix; i++)
            add_pixel(rand_pixel());
        wait_drained();
    endtask

    initial
    begin
        pix.valid = 1'b0;
        pix.red = '0;
        pix.green = '0;
        pix.blue = '0;
        pix.alpha = '0;
        tex.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // Extreme channel values on a 2x2 image, then a tiny image with no output.
        write_reg(REG_BASE_WIDTH, CFG_W'(2));
        write_reg(REG_BASE_HEIGHT, CFG_W'(2));
        add_pixel({4{8'hFF}});
        add_pixel({4{8'hFF}});
        add_pixel({4{8'hFF}});
        add_pixel({4{8'hFE}});
        add_pixel({4{8'h00}});
        add_pixel({4{8'h01}});
        add_pixel({4{8'h00}});
        add_pixel({4{8'h00}});
        wait_drained();
        run_image(0, 0, 3);
        run_image(3, 1, 4);
        run_image(1, 5, 6);
        run_image(8191, 1, 10);
        run_image(4096, 1, 8);
        run_image(5, 3, 15);
        run_image(7, 6, 14);
        run_image(8, 8, 32);
        run_image(4, 2, 10);
        for (int k = 0; k < 4; k++)
            run_image($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(3, 12));
        run_image(16, 2, 32);
        run_image(1, 4096, 32);
        wait_drained();
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
